// ===== rtl/core/iscm_pkg.sv =====
// Package with shared types, constants and codes of the intercom station call manager.
`default_nettype none
package iscm_pkg;
    localparam int STATIONS_DEF = 64;
    localparam logic [7:0] ESC_RESET = 8'd30;
    localparam logic [7:0] OFF_RESET = 8'd20;

    localparam logic [2:0] OP_POLL   = 3'd0;
    localparam logic [2:0] OP_REPLY  = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_ANSWER = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;
    localparam logic [2:0] OP_HOLD   = 3'd5;
    localparam logic [2:0] OP_RESUME = 3'd6;

    localparam logic [2:0] RK_POLL  = 3'd0;
    localparam logic [2:0] RK_TALK  = 3'd2;
    localparam logic [2:0] RK_HOLD  = 3'd3;
    localparam logic [2:0] RK_END   = 3'd4;
    localparam logic [2:0] RK_ALARM = 3'd5;
    localparam logic [2:0] RK_EVENT = 3'd6;

    localparam logic [7:0] FC_NORMAL = 8'd0;
    localparam logic [7:0] FC_CALL   = 8'd1;
    localparam logic [7:0] FC_TALK   = 8'd2;
    localparam logic [7:0] FC_HOLD   = 8'd3;

    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_QUEUED = 2'd1;
    localparam logic [1:0] PH_TALK   = 2'd2;
    localparam logic [1:0] PH_HOLD   = 2'd3;

    localparam int REG_ESC = 0;
    localparam int REG_OFF = 1;

    // Per-station record: phase, online, age, version, queued, wait, escalated.
    typedef struct packed {
        logic [1:0] phase;
        logic       online;
        logic [7:0] age;
        logic [7:0] version;
        logic       queued;
        logic [7:0] wait_s;
        logic       esc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
endpackage
`default_nettype wire

// ===== rtl/core/iscm_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module iscm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/intercom_station_call_manager.sv =====
// Top level of the intercom station call manager.
// An input beat on the s_axis channel carries one command: poll, station reply,
// second tick, answer, end call, hold or resume. Results leave on m_axis, one beat
// each, with tlast on the final beat caused by a command; many commands give none.
// Station records sit in one RAM, one word per station, walked by a small sequencer.
// A command on one station steps through read, wait, exec and out before the next beat is accepted.
// A second tick walks every station in turn, each through exec and out; an event
// found while an earlier one is still pending stays in exec until that one is sent.
// While busy the block holds s_axis_tready low; a stalled m_axis holds the walk.
// After reset a clearing pass writes every RAM word, during which no command
// is taken; APB writes are taken at any time.
// The two APB registers, escalation_secs and offline_secs, sit at 0x0 and 0x4.
`default_nettype none
module intercom_station_call_manager #(
    parameter int STATIONS = iscm_pkg::STATIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] operation, [10:3] station_address, [18:11] function_code,
    // [26:19] sw_version, [27] is_master, zero fill to 32
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] result_kind, [9:3] target_station, [10] went_offline,
    // [11] call_escalated, [12] alarm_cleared, [19:13] queue_count,
    // [20] call_active, [21] call_on_hold, zero fill to 24
    output logic      [23:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int AW = $clog2(STATIONS);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_WAIT  = 7'b0001000,
        ST_EXEC  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_NEXT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [7:0] r_esc, r_off;
    logic [2:0] r_op;
    logic [7:0] r_addr, r_fc, r_ver;
    logic       r_master;
    logic [AW-1:0] r_idx, n_idx;
    logic [6:0] r_next_poll, n_next_poll;
    logic [6:0] r_act_st, n_act_st;
    logic       r_act, n_act, r_hold, n_hold;
    logic [6:0] r_qtot, n_qtot;
    logic       r_pend, n_pend;
    logic [23:0] r_pdata, n_pdata;
    logic        r_ovalid, n_ovalid, r_olast, n_olast;
    logic [23:0] r_odata, n_odata;

    iscm_pkg::t_entry rd_e, wr_e;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [iscm_pkg::ENTRY_W-1:0] rdata;

    iscm_ram #(.WIDTH(iscm_pkg::ENTRY_W), .DEPTH(STATIONS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wr_e),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    assign rd_e = iscm_pkg::t_entry'(rdata);

    wire cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            1'b0:    prdata = {24'd0, r_esc};
            default: prdata = {24'd0, r_off};
        endcase
    end

    wire in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    wire out_free = !r_ovalid || m_axis_tready;

    wire addr_ok = (r_addr >= 8'd1) && (r_addr <= 8'(STATIONS));
    wire act_ok  = r_act && (r_act_st >= 7'd1) && (r_act_st <= 7'(STATIONS));
    wire [6:0] poll_s = ((r_next_poll >= 7'd1) && (r_next_poll <= 7'(STATIONS)))
                        ? r_next_poll : 7'd1;
    wire [AW-1:0] addr_i = AW'(r_addr - 8'd1);
    wire [AW-1:0] act_i  = AW'(r_act_st - 7'd1);
    wire [AW-1:0] poll_i = AW'(poll_s - 7'd1);
    wire last_idx = (r_idx == AW'(STATIONS - 1));

    function automatic logic [23:0] pack(input logic [2:0] k, input logic [6:0] t,
                                         input logic off, input logic esc,
                                         input logic clr);
        return {2'b00, 1'b0, 1'b0, 7'd0, clr, esc, off, t, k};
    endfunction

    logic [7:0] age_n, wait_n;
    logic off_ev, esc_ev;

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_next_poll = r_next_poll;
        n_act_st = r_act_st; n_act = r_act; n_hold = r_hold; n_qtot = r_qtot;
        n_pend = r_pend; n_pdata = r_pdata;
        n_ovalid = r_ovalid && !m_axis_tready; n_olast = r_olast; n_odata = r_odata;
        we = 1'b0; waddr = r_idx; wr_e = rd_e; raddr = r_idx;
        age_n = (rd_e.age == 8'hFF) ? rd_e.age : rd_e.age + 8'd1;
        wait_n = (rd_e.wait_s == 8'hFF) ? rd_e.wait_s : rd_e.wait_s + 8'd1;
        off_ev = r_master && rd_e.online && (age_n > r_off);
        esc_ev = rd_e.queued && !rd_e.esc && (wait_n >= r_esc);
        case (r_state)
            ST_CLEAR: begin
                we = 1'b1; wr_e = '0;
                n_idx = r_idx + AW'(1);
                if (last_idx) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                n_pend = 1'b0;
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_WAIT;
                case (r_op)
                    iscm_pkg::OP_POLL:   n_idx = poll_i;
                    iscm_pkg::OP_TICK:   n_idx = '0;
                    iscm_pkg::OP_REPLY,
                    iscm_pkg::OP_ANSWER: n_idx = addr_i;
                    default:             n_idx = act_i;
                endcase
                raddr = n_idx;
            end
            ST_WAIT: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                case (r_op)
                    iscm_pkg::OP_POLL: if (r_master) begin
                        n_next_poll = (poll_s >= 7'(STATIONS)) ? 7'd1 : poll_s + 7'd1;
                        n_pend = 1'b1;
                        n_pdata = pack({1'b0, rd_e.phase}, poll_s, 1'b0, 1'b0, 1'b0);
                    end
                    iscm_pkg::OP_REPLY: if (addr_ok) begin
                        we = 1'b1;
                        wr_e.online = 1'b1; wr_e.age = '0; wr_e.version = r_ver;
                        case (r_fc)
                            iscm_pkg::FC_NORMAL: wr_e.phase = iscm_pkg::PH_NORMAL;
                            iscm_pkg::FC_CALL: begin
                                wr_e.phase = iscm_pkg::PH_QUEUED;
                                if (!rd_e.queued) begin
                                    wr_e.queued = 1'b1; wr_e.wait_s = '0; wr_e.esc = 1'b0;
                                    if (r_qtot < 7'd127) n_qtot = r_qtot + 7'd1;
                                    n_pend = 1'b1;
                                    n_pdata = pack(iscm_pkg::RK_ALARM, r_addr[6:0],
                                                   1'b0, 1'b0, 1'b0);
                                end
                            end
                            iscm_pkg::FC_TALK: wr_e.phase = iscm_pkg::PH_TALK;
                            iscm_pkg::FC_HOLD: wr_e.phase = iscm_pkg::PH_HOLD;
                            default: ;
                        endcase
                    end
                    iscm_pkg::OP_TICK: begin
                        we = 1'b1;
                        wr_e.age = age_n;
                        if (off_ev) wr_e.online = 1'b0;
                        if (rd_e.queued && !rd_e.esc) begin
                            wr_e.wait_s = wait_n;
                            if (esc_ev) wr_e.esc = 1'b1;
                        end
                        if (off_ev || esc_ev) begin
                            n_pend = 1'b1;
                            n_pdata = pack(iscm_pkg::RK_EVENT, 7'(r_idx) + 7'd1,
                                           off_ev, esc_ev, 1'b0);
                        end
                    end
                    iscm_pkg::OP_ANSWER: if (r_master && addr_ok && rd_e.queued) begin
                        we = 1'b1;
                        wr_e.phase = iscm_pkg::PH_TALK; wr_e.queued = 1'b0;
                        wr_e.wait_s = '0; wr_e.esc = 1'b0;
                        n_act_st = r_addr[6:0]; n_act = 1'b1;
                        if (r_qtot > 7'd0) n_qtot = r_qtot - 7'd1;
                        n_pend = 1'b1;
                        n_pdata = pack(iscm_pkg::RK_TALK, r_addr[6:0], 1'b0, 1'b0, 1'b1);
                    end
                    iscm_pkg::OP_END: if (r_master && act_ok) begin
                        we = 1'b1;
                        wr_e.phase = iscm_pkg::PH_NORMAL; wr_e.wait_s = '0; wr_e.esc = 1'b0;
                        n_act = 1'b0; n_hold = 1'b0; n_act_st = '0;
                        n_pend = 1'b1;
                        n_pdata = pack(iscm_pkg::RK_END, r_act_st, 1'b0, 1'b0, 1'b1);
                    end
                    iscm_pkg::OP_HOLD: if (r_master && act_ok) begin
                        we = 1'b1; wr_e.phase = iscm_pkg::PH_HOLD; n_hold = 1'b1;
                        n_pend = 1'b1;
                        n_pdata = pack(iscm_pkg::RK_HOLD, r_act_st, 1'b0, 1'b0, 1'b0);
                    end
                    iscm_pkg::OP_RESUME: if (r_master && act_ok && r_hold) begin
                        we = 1'b1; wr_e.phase = iscm_pkg::PH_TALK; n_hold = 1'b0;
                        n_pend = 1'b1;
                        n_pdata = pack(iscm_pkg::RK_TALK, r_act_st, 1'b0, 1'b0, 1'b0);
                    end
                    default: ;
                endcase
                if (r_op == iscm_pkg::OP_TICK && r_pend && (off_ev || esc_ev)) begin
                    // A later event exists, so the pending one is not the last beat.
                    n_pend = r_pend; n_pdata = r_pdata;
                    n_state = ST_EXEC; we = 1'b0;
                    if (out_free) begin
                        n_ovalid = 1'b1; n_olast = 1'b0;
                        n_odata = r_pdata;
                        n_odata[21:13] = {r_hold, r_act, r_qtot};
                        n_pend = 1'b0;
                    end
                end
            end
            ST_OUT: begin
                if (r_op == iscm_pkg::OP_TICK && !last_idx) begin
                    n_state = ST_NEXT;
                    n_idx = r_idx + AW'(1);
                    raddr = n_idx;
                end else if (!r_pend) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_ovalid = 1'b1; n_olast = 1'b1;
                    n_odata = r_pdata;
                    n_odata[21:13] = {r_hold, r_act, r_qtot};
                    n_pend = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            ST_NEXT: begin
                n_state = ST_EXEC;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_idx <= '0; r_next_poll <= 7'd1;
            r_act_st <= '0; r_act <= 1'b0; r_hold <= 1'b0; r_qtot <= '0;
            r_pend <= 1'b0; r_ovalid <= 1'b0; r_olast <= 1'b0;
            r_esc <= iscm_pkg::ESC_RESET; r_off <= iscm_pkg::OFF_RESET;
        end else begin
            r_state <= n_state; r_idx <= n_idx; r_next_poll <= n_next_poll;
            r_act_st <= n_act_st; r_act <= n_act; r_hold <= n_hold; r_qtot <= n_qtot;
            r_pend <= n_pend; r_ovalid <= n_ovalid; r_olast <= n_olast;
            if (cfg_wr && paddr == 3'(4 * iscm_pkg::REG_ESC)) r_esc <= pwdata[7:0];
            if (cfg_wr && paddr == 3'(4 * iscm_pkg::REG_OFF)) r_off <= pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pdata <= n_pdata;
        r_odata <= n_odata;
        if (in_acc) begin
            r_op <= s_axis_tdata[2:0]; r_addr <= s_axis_tdata[10:3];
            r_fc <= s_axis_tdata[18:11]; r_ver <= s_axis_tdata[26:19];
            r_master <= s_axis_tdata[27];
        end
    end
endmodule
`default_nettype wire
